FILE: src/ihs_pkg.sv
// Package for the indexed heap sort block.
// Holds the fixed field widths shared by the interfaces and the RTL, and a store depth.
// No dependencies.
package ihs_pkg;

    localparam int KEY_FIELD_W = 32;
    localparam int IDX_W       = 6;
    localparam int STORE_DEPTH = 64;

endpackage

FILE: src/ihs_if.sv
// Valid/ready channel interfaces for the indexed heap sort block.
// Depends on ihs_pkg for the field widths.
interface ihs_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ihs_pkg::KEY_FIELD_W-1:0]  key;
    logic        [ihs_pkg::IDX_W-1:0]        index_in;
    logic                                    last_in;

    modport source (output valid, key, index_in, last_in, input ready);
    modport sink   (input valid, key, index_in, last_in, output ready);
endinterface

interface ihs_out_if;
    logic                                    valid;
    logic                                    ready;
    logic        [ihs_pkg::IDX_W-1:0]        sorted_index;
    logic signed [ihs_pkg::KEY_FIELD_W-1:0]  sorted_key;
    logic                                    last_out;

    modport source (output valid, sorted_index, sorted_key, last_out, input ready);
    modport sink   (input valid, sorted_index, sorted_key, last_out, output ready);
endinterface

FILE: src/ihs_ram.sv
// Synchronous memory with one write port and two registered read ports.
// Used for the index list and the key store; no package dependency.
module ihs_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re_a,
    input  logic [AW-1:0] i_raddr_a,
    output logic [DW-1:0] o_rdata_a,
    input  logic          i_re_b,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read on the same port.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/indexed_heap_sort.sv
// Indexed heap sort: loads up to MAX_ENTRIES requests on i_in, each a signed key
// stored at the next load position plus an index word for the index list. The
// request with last_in set starts an indirect max-heap sort of the index list by
// key; keys never move. Requests that arrive once MAX_ENTRIES are held are dropped,
// but a last_in on one still starts the sort of the stored set.
// Loading takes one request per cycle. i_in.ready is low from the last request
// until the final sorted result has been taken.
// The sort is paced by the single index memory and key memory, whose reads are
// registered. Every sift-down runs a setup (index read, key read, key latch),
// then for each heap level it descends an index read, a key read, and a compare
// and write back, and it places the element with a final index write. Each result
// then passes through index read, key read, output register and handshake; the
// next result is not read until it is taken, and a stalled receiver simply holds
// the result in the output register. Results come in ascending key order with
// last_out on the n-th.
// Reset (synchronous, active low) empties the set and drops any result pending;
// memory contents are kept and need no clearing.
module indexed_heap_sort #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ihs_in_if.sink    i_in,
    ihs_out_if.source o_out
);

    localparam int KW = (KEY_BITS < ihs_pkg::KEY_FIELD_W) ? KEY_BITS : ihs_pkg::KEY_FIELD_W;
    localparam int PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [10:0] {
        S_LOAD      = 11'b000_0000_0001,
        S_ROOT      = 11'b000_0000_0010,
        S_RKEY      = 11'b000_0000_0100,
        S_KLATCH    = 11'b000_0000_1000,
        S_SIFT_A    = 11'b000_0001_0000,
        S_SIFT_B    = 11'b000_0010_0000,
        S_SIFT_C    = 11'b000_0100_0000,
        S_EMIT_RD   = 11'b000_1000_0000,
        S_EMIT_KEY  = 11'b001_0000_0000,
        S_EMIT_OUT  = 11'b010_0000_0000,
        S_EMIT_WAIT = 11'b100_0000_0000
    } t_state;

    function automatic logic f_less(input logic [KW-1:0] a, input logic [KW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    t_state r_state, n_state;

    logic [CW-1:0]             r_cnt;
    logic [CW-1:0]             r_n;
    logic [PW-1:0]             r_s;
    logic [PW-1:0]             r_e;
    logic                      r_extract;
    logic [PW-1:0]             r_r;
    logic [CW-1:0]             r_lim;
    logic [ihs_pkg::IDX_W-1:0] r_sift_idx;
    logic [KW-1:0]             r_sift_key;
    logic                      r_c1_ok;
    logic [PW-1:0]             r_child;
    logic [PW-1:0]             r_emit;
    logic                      r_out_valid;
    logic [ihs_pkg::IDX_W-1:0] r_out_index;
    logic [KW-1:0]             r_out_key;
    logic                      r_out_last;

    // Index memory: load position -> index word.
    logic                      idx_we, idx_re_a, idx_re_b;
    logic [PW-1:0]             idx_waddr, idx_raddr_a, idx_raddr_b;
    logic [ihs_pkg::IDX_W-1:0] idx_wdata, idx_rd_a, idx_rd_b;

    // Key memory: load position -> key, read by index word.
    logic                      key_we, key_re_a, key_re_b;
    logic [ihs_pkg::IDX_W-1:0] key_waddr, key_raddr_a, key_raddr_b;
    logic [KW-1:0]             key_wdata, key_rd_a, key_rd_b;

    logic                      in_acc, out_acc;
    logic [CW-1:0]             w_cnt_new;
    logic [CW-1:0]             w_child, w_child1;
    logic                      w_has_child;
    logic                      w_big_b;
    logic [ihs_pkg::IDX_W-1:0] w_big_idx;
    logic [KW-1:0]             w_big_key;
    logic                      w_swap;
    logic                      w_sift_done;

    ihs_ram #(.AW(PW), .DW(ihs_pkg::IDX_W)) u_idx_ram (
        .i_clk     (i_clk),
        .i_we      (idx_we),
        .i_waddr   (idx_waddr),
        .i_wdata   (idx_wdata),
        .i_re_a    (idx_re_a),
        .i_raddr_a (idx_raddr_a),
        .o_rdata_a (idx_rd_a),
        .i_re_b    (idx_re_b),
        .i_raddr_b (idx_raddr_b),
        .o_rdata_b (idx_rd_b)
    );

    ihs_ram #(.AW(ihs_pkg::IDX_W), .DW(KW)) u_key_ram (
        .i_clk     (i_clk),
        .i_we      (key_we),
        .i_waddr   (key_waddr),
        .i_wdata   (key_wdata),
        .i_re_a    (key_re_a),
        .i_raddr_a (key_raddr_a),
        .o_rdata_a (key_rd_a),
        .i_re_b    (key_re_b),
        .i_raddr_b (key_raddr_b),
        .o_rdata_b (key_rd_b)
    );

    assign i_in.ready         = (r_state == S_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_index = r_out_index;
    assign o_out.sorted_key   = ihs_pkg::KEY_FIELD_W'($signed(r_out_key));
    assign o_out.last_out     = r_out_last;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    assign w_cnt_new   = (r_cnt < MAX_CNT) ? r_cnt + 1'b1 : r_cnt;
    assign w_child     = {r_r, 1'b1};
    assign w_child1    = w_child + 1'b1;
    assign w_has_child = (w_child < r_lim);

    // The element being sifted sits in a hole at r_r; its key is cached, so each
    // level only compares the two children against it.
    assign w_big_b   = r_c1_ok && f_less(key_rd_a, key_rd_b);
    assign w_big_idx = w_big_b ? idx_rd_b : idx_rd_a;
    assign w_big_key = w_big_b ? key_rd_b : key_rd_a;
    assign w_swap    = f_less(r_sift_key, w_big_key);

    assign w_sift_done = ((r_state == S_SIFT_A) && !w_has_child) ||
                         ((r_state == S_SIFT_C) && !w_swap);

    always_comb begin
        idx_we      = 1'b0;
        idx_waddr   = r_r;
        idx_wdata   = r_sift_idx;
        idx_re_a    = 1'b0;
        idx_raddr_a = r_s;
        idx_re_b    = 1'b0;
        idx_raddr_b = r_e;
        key_we      = 1'b0;
        key_waddr   = ihs_pkg::IDX_W'(r_cnt[PW-1:0]);
        key_wdata   = i_in.key[KW-1:0];
        key_re_a    = 1'b0;
        key_raddr_a = idx_rd_a;
        key_re_b    = 1'b0;
        key_raddr_b = idx_rd_b;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && (r_cnt < MAX_CNT)) begin
                    idx_we    = 1'b1;
                    idx_waddr = r_cnt[PW-1:0];
                    idx_wdata = i_in.index_in;
                    key_we    = 1'b1;
                end
            end
            S_ROOT: begin
                idx_re_a    = 1'b1;
                idx_raddr_a = r_extract ? '0 : r_s;
                idx_re_b    = r_extract;
            end
            S_RKEY: begin
                key_re_a    = 1'b1;
                key_raddr_a = r_extract ? idx_rd_b : idx_rd_a;
                // Extraction: the old root moves to the end of the heap.
                if (r_extract) begin
                    idx_we    = 1'b1;
                    idx_waddr = r_e;
                    idx_wdata = idx_rd_a;
                end
            end
            S_KLATCH: begin
            end
            S_SIFT_A: begin
                if (w_has_child) begin
                    idx_re_a    = 1'b1;
                    idx_raddr_a = w_child[PW-1:0];
                    idx_re_b    = 1'b1;
                    idx_raddr_b = w_child1[PW-1:0];
                end else begin
                    idx_we = 1'b1;
                end
            end
            S_SIFT_B: begin
                key_re_a = 1'b1;
                key_re_b = 1'b1;
            end
            S_SIFT_C: begin
                idx_we    = 1'b1;
                idx_wdata = w_swap ? w_big_idx : r_sift_idx;
            end
            S_EMIT_RD: begin
                idx_re_a    = 1'b1;
                idx_raddr_a = r_emit;
            end
            S_EMIT_KEY: begin
                key_re_a = 1'b1;
            end
            S_EMIT_OUT: begin
            end
            S_EMIT_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_in.last_in) begin
                    n_state = (w_cnt_new > CW'(1)) ? S_ROOT : S_EMIT_RD;
                end
            end
            S_ROOT:     n_state = S_RKEY;
            S_RKEY:     n_state = S_KLATCH;
            S_KLATCH:   n_state = S_SIFT_A;
            S_SIFT_A:   n_state = w_has_child ? S_SIFT_B : S_ROOT;
            S_SIFT_B:   n_state = S_SIFT_C;
            S_SIFT_C:   n_state = w_swap ? S_SIFT_A : S_ROOT;
            S_EMIT_RD:  n_state = S_EMIT_KEY;
            S_EMIT_KEY: n_state = S_EMIT_OUT;
            S_EMIT_OUT: n_state = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (out_acc) begin
                    n_state = r_out_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:    n_state = S_LOAD;
        endcase
        // The last extraction step hands over to the output phase.
        if (w_sift_done && r_extract && (r_e == PW'(1))) begin
            n_state = S_EMIT_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= w_cnt_new;
            end
            if (r_state == S_EMIT_OUT) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
                if (r_out_last) begin
                    r_cnt <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_in) begin
            r_n       <= w_cnt_new;
            r_s       <= w_cnt_new[CW-1:1] - 1'b1;
            r_extract <= 1'b0;
            r_emit    <= '0;
        end
        if (r_state == S_RKEY) begin
            r_sift_idx <= r_extract ? idx_rd_b : idx_rd_a;
            r_r        <= r_extract ? '0 : r_s;
            r_lim      <= r_extract ? {1'b0, r_e} : r_n;
        end
        if (r_state == S_KLATCH) begin
            r_sift_key <= key_rd_a;
        end
        if ((r_state == S_SIFT_A) && w_has_child) begin
            r_c1_ok <= (w_child1 < r_lim);
            r_child <= w_child[PW-1:0];
        end
        if ((r_state == S_SIFT_C) && w_swap) begin
            r_r <= w_big_b ? r_child + 1'b1 : r_child;
        end
        if (w_sift_done) begin
            if (!r_extract) begin
                if (r_s == '0) begin
                    r_extract <= 1'b1;
                    r_e       <= PW'(r_n - 1'b1);
                end else begin
                    r_s <= r_s - 1'b1;
                end
            end else if (r_e != PW'(1)) begin
                r_e <= r_e - 1'b1;
            end
        end
        if (r_state == S_EMIT_OUT) begin
            r_out_index <= idx_rd_a;
            r_out_key   <= key_rd_a;
            r_out_last  <= (({1'b0, r_emit} + 1'b1) == r_n);
        end
        if ((r_state == S_EMIT_WAIT) && out_acc) begin
            r_emit <= r_emit + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_load_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input accepted while a sorted result is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("load count beyond the maximum set size");

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_out) |=> (i_in.ready && !o_out.valid))
        else $error("block did not return to loading after the final result");

    a_sift_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIFT_B) |-> ({1'b0, r_child} < r_lim))
        else $error("sift read a child outside the heap");
`endif

endmodule
